### rtl/core/turtle_command_stream_interpreter_top_assert.svh
// Assertion macros used by the turtle interpreter RTL.
`ifndef TURTLE_COMMAND_STREAM_INTERPRETER_TOP_ASSERT_SVH
`define TURTLE_COMMAND_STREAM_INTERPRETER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define TSI_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("tsi: implication check failed");
// Next-cycle implication, disabled while in reset.
`define TSI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("tsi: next-cycle check failed");
`else
`define TSI_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define TSI_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

### rtl/core/tsi_pkg.sv
// Shared types, codes and keyword tables of the turtle interpreter.
package tsi_pkg;

	// Word types on the two streaming channels
	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] x_pos;
		logic signed [15:0] y_pos;
		logic [1:0]         heading;
		logic               last;
	} res_t;

	// Push request from the interpreter into the result queue
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_MOVE  = 2'd1,
		KIND_END   = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// Headings
	typedef enum logic [1:0] {
		HD_NORTH = 2'd0,
		HD_EAST  = 2'd1,
		HD_SOUTH = 2'd2,
		HD_WEST  = 2'd3
	} hd_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_START_X       = 2'd0,
		CFG_START_Y       = 2'd1,
		CFG_START_HEADING = 2'd2
	} cfg_idx_t;

	// Character classes; CLS_NONE doubles as "no token pending"
	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_ALPHA = 2'd1,
		CLS_DIGIT = 2'd2,
		CLS_OTHER = 2'd3
	} cls_t;

	// Tokens seen by the parser
	typedef enum logic [2:0] {
		TK_START,
		TK_FWD,
		TK_BACK,
		TK_LEFT,
		TK_RIGHT,
		TK_END,
		TK_NUM,
		TK_BAD
	} tok_t;

	// Keyword table, text left-justified, first character in the top byte
	localparam int KW_COUNT = 6;
	localparam int KW_CHARS = 9;
	localparam int KW_BITS  = KW_CHARS * 8;

	localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		{"inicio", 24'h0},
		{"avanza", 24'h0},
		{"retrocede"},
		{"izquierda"},
		{"derecha", 16'h0},
		{"final", 32'h0}
	};
	localparam int   KW_LEN [KW_COUNT] = '{6, 6, 9, 9, 7, 5};
	localparam tok_t KW_TOK [KW_COUNT] = '{TK_START, TK_FWD, TK_BACK, TK_LEFT, TK_RIGHT, TK_END};

	// Classify one byte of program text
	function automatic cls_t char_class(input logic [7:0] c);
		cls_t cls;
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
			cls = CLS_ALPHA;
		end else if (c >= "0" && c <= "9") begin
			cls = CLS_DIGIT;
		end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
			cls = CLS_NONE;
		end else begin
			cls = CLS_OTHER;
		end
		return cls;
	endfunction

endpackage

### rtl/core/turtle_command_stream_interpreter_top.sv
// Turtle command stream interpreter: top level.
//
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) takes one byte of program text, or
//   an end mark, per word. res channel (res_valid/res_stall/res) gives
//   start, move, end and error events with the position and heading after
//   each. One input word gives zero, one or two result words; last marks
//   the final one of each input word.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the start
//   position and heading; write it only while the block is idle.
// Timing:
//   A byte is taken every cycle while the input does not stall. It is held in the input register,
//   where the lexer, keyword compare and parser run in one pass, and its
//   results are written into the four-word queue when the byte is consumed.
//   Results leave at one word a cycle while the receiver does not stall.
//   Input stalls only while the queue has room for fewer than two words.
// Reset:
//   Start registers return to x = 4, y = 4, heading north; the parser waits
//   for the start keyword. A stalled receiver fills the queue, then the
//   input stalls; nothing is lost.
`include "turtle_command_stream_interpreter_top_assert.svh"

module turtle_command_stream_interpreter_top #(
	parameter int COORD_BITS = 16,
	parameter int DIST_BITS  = 16,
	parameter int WORD_CHARS = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tsi_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output tsi_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam int LEN_BITS = $clog2(WORD_CHARS + 2);
	localparam int IDX_BITS = $clog2(WORD_CHARS);
	localparam int ACC_BITS = DIST_BITS + 4;

	typedef enum logic [2:0] {
		PH_START,
		PH_BLOCK,
		PH_NUMF,
		PH_NUMB,
		PH_DONE,
		PH_ERR
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [1:0]            h;
		logic                  emit;
		tsi_pkg::kind_t        kind;
	} ev_t;

	// Configuration
	logic signed [15:0] start_x_q;
	logic signed [15:0] start_y_q;
	logic [1:0]         start_h_q;

	// Input register
	logic          s1_valid_q;
	tsi_pkg::cmd_t cmd_s1;

	// Token and parser state
	logic [7:0]            word_q [WORD_CHARS];
	logic [LEN_BITS-1:0]   wlen_q;
	tsi_pkg::cls_t         tclass_q;
	logic [DIST_BITS-1:0]  num_q;
	phase_t                phase_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [1:0]            h_q;

	// Pass logic
	logic                  room;
	logic                  consume;
	tsi_pkg::cls_t         cls;
	logic                  eoi;
	logic                  do_flush;
	tsi_pkg::tok_t         tok_word;
	tsi_pkg::tok_t         flush_tok;
	ev_t                   cur_ev;
	ev_t                   start_ev;
	ev_t                   ev1;
	ev_t                   ev2;
	logic                  bad2;
	tsi_pkg::push_t        push;
	tsi_pkg::res_t         r0;
	tsi_pkg::res_t         r1;
	logic [LEN_BITS-1:0]   base_len;
	logic [DIST_BITS-1:0]  base_num;
	logic [ACC_BITS-1:0]   acc;
	logic [LEN_BITS-1:0]   wlen_n;
	tsi_pkg::cls_t         tclass_n;
	logic [DIST_BITS-1:0]  num_n;
	logic                  wr_char;

	// Apply one token to the parser
	function automatic ev_t parse_tok(input ev_t cur, input ev_t st, input tsi_pkg::tok_t tok,
			input logic [COORD_BITS-1:0] move_len);
		ev_t        nx;
		logic [1:0] mh;
		nx      = cur;
		nx.emit = 1'b0;
		nx.kind = tsi_pkg::KIND_ERROR;
		mh      = cur.h + ((cur.phase == PH_NUMB) ? 2'd2 : 2'd0);
		case (cur.phase)
			PH_START: begin
				nx.emit = 1'b1;
				if (tok == tsi_pkg::TK_START) begin
					nx       = st;
					nx.phase = PH_BLOCK;
					nx.emit  = 1'b1;
					nx.kind  = tsi_pkg::KIND_START;
				end else begin
					nx.phase = PH_ERR;
				end
			end
			PH_BLOCK: begin
				case (tok)
					tsi_pkg::TK_FWD:  nx.phase = PH_NUMF;
					tsi_pkg::TK_BACK: nx.phase = PH_NUMB;
					tsi_pkg::TK_LEFT: begin
						nx.h    = cur.h - 2'd1;
						nx.emit = 1'b1;
						nx.kind = tsi_pkg::KIND_MOVE;
					end
					tsi_pkg::TK_RIGHT: begin
						nx.h    = cur.h + 2'd1;
						nx.emit = 1'b1;
						nx.kind = tsi_pkg::KIND_MOVE;
					end
					tsi_pkg::TK_END: begin
						nx.phase = PH_DONE;
						nx.emit  = 1'b1;
						nx.kind  = tsi_pkg::KIND_END;
					end
					default: begin
						nx.phase = PH_ERR;
						nx.emit  = 1'b1;
					end
				endcase
			end
			PH_NUMF, PH_NUMB: begin
				nx.emit = 1'b1;
				if (tok == tsi_pkg::TK_NUM) begin
					nx.phase = PH_BLOCK;
					nx.kind  = tsi_pkg::KIND_MOVE;
					case (tsi_pkg::hd_t'(mh))
						tsi_pkg::HD_NORTH: nx.y = cur.y - move_len;
						tsi_pkg::HD_EAST:  nx.x = cur.x + move_len;
						tsi_pkg::HD_SOUTH: nx.y = cur.y + move_len;
						default:           nx.x = cur.x - move_len;
					endcase
				end else begin
					nx.phase = PH_ERR;
				end
			end
			default: ;
		endcase
		return nx;
	endfunction

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= 16'sd4;
			start_y_q <= 16'sd4;
			start_h_q <= tsi_pkg::HD_NORTH;
		end else if (cfg_valid && cfg_ready) begin
			case (tsi_pkg::cfg_idx_t'(cfg_index))
				tsi_pkg::CFG_START_X:       start_x_q <= cfg_data;
				tsi_pkg::CFG_START_Y:       start_y_q <= cfg_data;
				tsi_pkg::CFG_START_HEADING: start_h_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Input register handshake
	assign consume   = s1_valid_q && room;
	assign cmd_stall = s1_valid_q && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!cmd_stall) begin
			s1_valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Lexer: class of the byte and whether it closes a pending token
	assign cls      = tsi_pkg::char_class(cmd_s1.char_code);
	assign eoi      = cmd_s1.end_of_input;
	assign do_flush = (tclass_q != tsi_pkg::CLS_NONE) && (eoi || cls != tclass_q);

	// Keyword compare, all keywords in parallel
	always_comb begin
		logic hit;
		tok_word = tsi_pkg::TK_BAD;
		for (int k = 0; k < tsi_pkg::KW_COUNT; k++) begin
			hit = (wlen_q == LEN_BITS'(tsi_pkg::KW_LEN[k]));
			for (int j = 0; j < tsi_pkg::KW_CHARS; j++) begin
				if (j < tsi_pkg::KW_LEN[k] &&
						word_q[j] != tsi_pkg::KW_TEXT[k][8*(tsi_pkg::KW_CHARS-1-j) +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				tok_word = tsi_pkg::KW_TOK[k];
			end
		end
	end

	assign flush_tok = (tclass_q == tsi_pkg::CLS_ALPHA) ? tok_word : tsi_pkg::TK_NUM;

	// Parser: flushed token first, then a bad byte or an early end
	always_comb begin
		cur_ev       = '{phase: phase_q, x: x_q, y: y_q, h: h_q, emit: 1'b0,
			kind: tsi_pkg::KIND_ERROR};
		start_ev     = cur_ev;
		start_ev.x   = COORD_BITS'(start_x_q);
		start_ev.y   = COORD_BITS'(start_y_q);
		start_ev.h   = start_h_q;
		ev1          = do_flush ? parse_tok(cur_ev, start_ev, flush_tok, COORD_BITS'(num_q))
			: cur_ev;
		bad2         = (eoi || cls == tsi_pkg::CLS_OTHER) &&
			ev1.phase != PH_DONE && ev1.phase != PH_ERR;
		ev2          = ev1;
		ev2.emit     = bad2;
		ev2.kind     = tsi_pkg::KIND_ERROR;
		if (bad2) begin
			ev2.phase = PH_ERR;
		end
	end

	// Result words for the queue
	always_comb begin
		r1.kind    = ev2.kind;
		r1.x_pos   = 16'(ev2.x);
		r1.y_pos   = 16'(ev2.y);
		r1.heading = ev2.h;
		r1.last    = 1'b1;
		if (ev1.emit) begin
			r0.kind    = ev1.kind;
			r0.x_pos   = 16'(ev1.x);
			r0.y_pos   = 16'(ev1.y);
			r0.heading = ev1.h;
			r0.last    = !bad2;
			push.first  = consume;
			push.second = consume && bad2;
		end else begin
			r0          = r1;
			push.first  = consume && bad2;
			push.second = 1'b0;
		end
	end

	// Token accumulation after any flush
	always_comb begin
		base_len = do_flush ? '0 : wlen_q;
		base_num = do_flush ? '0 : num_q;
		acc      = ACC_BITS'({base_num, 3'b000}) + ACC_BITS'({base_num, 1'b0})
			+ ACC_BITS'(cmd_s1.char_code[3:0]);
		wlen_n   = base_len;
		num_n    = base_num;
		tclass_n = do_flush ? tsi_pkg::CLS_NONE : tclass_q;
		wr_char  = 1'b0;
		if (!eoi && cls == tsi_pkg::CLS_ALPHA) begin
			tclass_n = tsi_pkg::CLS_ALPHA;
			wr_char  = consume && (base_len < LEN_BITS'(WORD_CHARS));
			if (base_len <= LEN_BITS'(WORD_CHARS)) begin
				wlen_n = base_len + LEN_BITS'(1);
			end
		end else if (!eoi && cls == tsi_pkg::CLS_DIGIT) begin
			tclass_n = tsi_pkg::CLS_DIGIT;
			num_n    = (|acc[ACC_BITS-1:DIST_BITS]) ? '1 : acc[DIST_BITS-1:0];
		end
	end

	// Parser and token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= '0;
			tclass_q <= tsi_pkg::CLS_NONE;
			num_q    <= '0;
			phase_q  <= PH_START;
			x_q      <= COORD_BITS'(4);
			y_q      <= COORD_BITS'(4);
			h_q      <= tsi_pkg::HD_NORTH;
		end else if (consume) begin
			wlen_q   <= wlen_n;
			tclass_q <= tclass_n;
			num_q    <= num_n;
			phase_q  <= ev2.phase;
			x_q      <= ev2.x;
			y_q      <= ev2.y;
			h_q      <= ev2.h;
		end
	end

	// Letters of the pending word
	always_ff @(posedge clk) begin
		if (wr_char) begin
			word_q[base_len[IDX_BITS-1:0]] <= cmd_s1.char_code;
		end
	end

	tsi_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data0     (r0),
		.data1     (r1),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Checks
	`TSI_ASSERT_NEXT(a_err_sticky, clk, arst_n, phase_q == PH_ERR, phase_q == PH_ERR)
	`TSI_ASSERT_NEXT(a_done_holds, clk, arst_n, phase_q == PH_DONE, phase_q == PH_DONE)
	`TSI_ASSERT_IMPLY(a_no_push_when_over, clk, arst_n, phase_q == PH_DONE || phase_q == PH_ERR, !push.first && !push.second)
	`TSI_ASSERT_IMPLY(a_len_only_in_word, clk, arst_n, tclass_q != tsi_pkg::CLS_ALPHA, wlen_q == '0)
	`TSI_ASSERT_IMPLY(a_num_only_in_digits, clk, arst_n, tclass_q != tsi_pkg::CLS_DIGIT, num_q == '0)

endmodule

### rtl/core/tsi_res_queue.sv
// Four-entry result queue: takes up to two result words a cycle, gives one unless the receiver stalls.
module tsi_res_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  tsi_pkg::push_t push,
	input  tsi_pkg::res_t  data0,
	input  tsi_pkg::res_t  data1,
	output logic           room,
	output logic           res_valid,
	input  logic           res_stall,
	output tsi_pkg::res_t  res
);

	localparam int DEPTH    = 4;
	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	tsi_pkg::res_t        mem_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 pop;
	logic [CNT_BITS-1:0]  n_push;
	logic [PTR_BITS-1:0]  wr_ptr_p1;

	// Pop when a word is shown and not stalled
	assign pop       = res_valid && !res_stall;
	assign n_push    = CNT_BITS'(push.first) + CNT_BITS'(push.second);
	assign wr_ptr_p1 = wr_ptr_q + PTR_BITS'(1);
	// Room for the worst case of two words from one item
	assign room      = cnt_q <= CNT_BITS'(DEPTH - 2);
	assign res_valid = cnt_q != '0;
	assign res       = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			cnt_q <= cnt_q + n_push - CNT_BITS'(pop);
		end
	end

	// Storage; the second word goes behind the first
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_ptr_q] <= data0;
		end
		if (push.second) begin
			mem_q[wr_ptr_p1] <= data1;
		end
	end

endmodule
